/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled during reset.
`define WSRM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked implication, antecedent on one edge, consequent on the next.
`define WSRM_ASSERT_NEXT(label, ante, cons, msg) \
	`WSRM_ASSERT(label, (ante) |=> (cons), msg)

`endif

/* src/wsrm_pkg.sv */
`timescale 1ns / 1ps
package wsrm_pkg;

	localparam int PATTERN_MAX_DEF = 32;
	localparam int PLEN_W = 6;
	localparam int WORD_W = 64;
	localparam int NUM_WORDS = 4;
	localparam int IDX_W = 3;
	localparam int CHAR_W = 8;

	localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
	localparam logic [CHAR_W-1:0] DOT_CHAR = 8'h2E;

	typedef enum logic [IDX_W-1:0] {
		REG_PATTERN_LENGTH = 3'd0,
		REG_CHARS_A = 3'd1,
		REG_CHARS_B = 3'd2,
		REG_CHARS_C = 3'd3,
		REG_CHARS_D = 3'd4
	} reg_idx_t;

	typedef enum logic {
		CMD_BYTE = 1'b0,
		CMD_END = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [PLEN_W-1:0] pattern_length;
		logic [NUM_WORDS-1:0][WORD_W-1:0] chars;
	} cfg_t;

endpackage

/* src/wildcard_star_regex_matcher.sv */
`timescale 1ns / 1ps
// channel   direction  handshake                 payload
// in        sink       in_valid / in_stall       cmd, subject_byte
// out       source     out_valid / out_stall     matched
// cfg       sink       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One word per cycle while in_stall is low; an end word's matched is registered at out after the input stage.
// Cycle time is set by the star-skip closure prefix plus the char compare.
// Byte words never stall; an end word waits in the input stage while a result on out is stalled.
// arst_n clears the pattern registers and leaves only position zero active.
`include "assert_macros.svh"
module wildcard_star_regex_matcher #(
	parameter int PATTERN_MAX = wsrm_pkg::PATTERN_MAX_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic cmd,
	input logic [wsrm_pkg::CHAR_W-1:0] subject_byte,
	output logic out_valid,
	input logic out_stall,
	output logic matched,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [wsrm_pkg::IDX_W-1:0] cfg_index,
	input logic [wsrm_pkg::WORD_W-1:0] cfg_data
);
	import wsrm_pkg::*;

	cfg_t cfg;
	logic valid_s1;
	logic cmd_s1;
	logic [CHAR_W-1:0] byte_s1;
	logic s1_go;
	logic in_acc;
	logic step_en;
	logic nfa_matched;
	logic out_valid_q;
	logic matched_q;

	wsrm_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	wsrm_nfa #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_nfa (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.step_en(step_en),
		.step_cmd(cmd_s1),
		.step_byte(byte_s1),
		.matched(nfa_matched)
	);

	assign s1_go = (cmd_s1 == CMD_BYTE) || !out_valid_q || !out_stall;
	assign step_en = valid_s1 && s1_go;
	assign in_stall = valid_s1 && !s1_go;
	assign in_acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc || (valid_s1 && !s1_go);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1 <= cmd;
			byte_s1 <= subject_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en && (cmd_s1 == CMD_END)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && (cmd_s1 == CMD_END)) begin
			matched_q <= nfa_matched;
		end
	end

	assign out_valid = out_valid_q;
	assign matched = matched_q;

	`WSRM_ASSERT(a_byte_no_stall, (valid_s1 && (cmd_s1 == CMD_BYTE)) |-> !in_stall,
		"byte word stalled the input")
	`WSRM_ASSERT(a_end_blocked, (valid_s1 && (cmd_s1 == CMD_END) && out_valid_q && out_stall)
		|-> in_stall, "end word advanced over a held result")
	`WSRM_ASSERT(a_result_source, $rose(out_valid_q) |-> $past(valid_s1 && (cmd_s1 == CMD_END)),
		"result raised without an end word")

endmodule

/* src/wsrm_cfg.sv */
`timescale 1ns / 1ps
module wsrm_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [wsrm_pkg::IDX_W-1:0] cfg_index,
	input logic [wsrm_pkg::WORD_W-1:0] cfg_data,
	output wsrm_pkg::cfg_t cfg
);
	import wsrm_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PATTERN_LENGTH: begin
					cfg_q.pattern_length <= cfg_data[PLEN_W-1:0];
				end
				REG_CHARS_A: begin
					cfg_q.chars[0] <= cfg_data;
				end
				REG_CHARS_B: begin
					cfg_q.chars[1] <= cfg_data;
				end
				REG_CHARS_C: begin
					cfg_q.chars[2] <= cfg_data;
				end
				REG_CHARS_D: begin
					cfg_q.chars[3] <= cfg_data;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

endmodule

/* src/wsrm_nfa.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wsrm_nfa #(
	parameter int PATTERN_MAX = wsrm_pkg::PATTERN_MAX_DEF
) (
	input logic clk,
	input logic arst_n,
	input wsrm_pkg::cfg_t cfg,
	input logic step_en,
	input logic step_cmd,
	input logic [wsrm_pkg::CHAR_W-1:0] step_byte,
	output logic matched
);
	import wsrm_pkg::*;

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int NUM_LVL = ($clog2(PATTERN_MAX + 2) > 1) ? $clog2(PATTERN_MAX + 2) - 1 : 1;

	logic [PATTERN_MAX:0] active_q;
	logic [LEN_W-1:0] len_eff;
	logic [PATTERN_MAX-1:0][CHAR_W-1:0] pchar;
	logic [PATTERN_MAX-1:0] star_nxt;
	logic [PATTERN_MAX-1:0] hit;
	logic [PATTERN_MAX:0] keep;
	logic [PATTERN_MAX:0] prop0;
	logic [PATTERN_MAX:0] cur;
	logic [PATTERN_MAX:0] nxt;
	logic [PATTERN_MAX:0] g_lvl [NUM_LVL+1];
	logic [PATTERN_MAX:0] p_lvl [NUM_LVL+1];

	assign len_eff = (cfg.pattern_length > PLEN_W'(PATTERN_MAX)) ?
		LEN_W'(PATTERN_MAX) : cfg.pattern_length[LEN_W-1:0];

	for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_pos
		assign pchar[j] = cfg.chars[j / 8][(j % 8) * CHAR_W +: CHAR_W];
		if (j < PATTERN_MAX - 1) begin : g_star
			assign star_nxt[j] = (LEN_W'(j + 1) < len_eff) && (pchar[j + 1] == STAR_CHAR);
		end else begin : g_nostar
			assign star_nxt[j] = 1'b0;
		end
		assign hit[j] = cur[j] && (LEN_W'(j) < len_eff) &&
			((pchar[j] == DOT_CHAR) || (pchar[j] == step_byte));
	end

	for (genvar k = 0; k <= PATTERN_MAX; k++) begin : g_bit
		assign keep[k] = (LEN_W'(k) <= len_eff);
		if (k >= 2) begin : g_p
			assign prop0[k] = star_nxt[k - 2];
		end else begin : g_np
			assign prop0[k] = 1'b0;
		end
		if (k == 0) begin : g_n0
			assign nxt[k] = hit[k] & star_nxt[k];
		end else if (k < PATTERN_MAX) begin : g_nm
			assign nxt[k] = (hit[k] & star_nxt[k]) | (hit[k - 1] & ~star_nxt[k - 1]);
		end else begin : g_nl
			assign nxt[k] = hit[k - 1] & ~star_nxt[k - 1];
		end
	end

	// star-skip closure as a stride-2 parallel prefix
	always_comb begin
		int d;
		g_lvl[0] = active_q & keep;
		p_lvl[0] = prop0;
		for (int l = 0; l < NUM_LVL; l++) begin
			d = 2 << l;
			for (int k = 0; k <= PATTERN_MAX; k++) begin
				if (k >= d) begin
					g_lvl[l + 1][k] = g_lvl[l][k] | (p_lvl[l][k] & g_lvl[l][k - d]);
					p_lvl[l + 1][k] = p_lvl[l][k] & p_lvl[l][k - d];
				end else begin
					g_lvl[l + 1][k] = g_lvl[l][k];
					p_lvl[l + 1][k] = p_lvl[l][k];
				end
			end
		end
	end

	assign cur = g_lvl[NUM_LVL];
	assign matched = cur[len_eff];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= (PATTERN_MAX + 1)'(1);
		end else if (step_en) begin
			if (step_cmd == CMD_END) begin
				active_q <= (PATTERN_MAX + 1)'(1);
			end else begin
				active_q <= nxt;
			end
		end
	end

	`WSRM_ASSERT_NEXT(a_end_restart, step_en && (step_cmd == CMD_END),
		active_q == (PATTERN_MAX + 1)'(1), "end word did not restart the match")
	`WSRM_ASSERT_NEXT(a_hold_idle, !step_en, $stable(active_q),
		"active set changed without a word")
	`WSRM_ASSERT_NEXT(a_empty_pattern, step_en && (step_cmd == CMD_BYTE) && (len_eff == '0),
		active_q == '0, "empty pattern consumed a byte")

endmodule
